// File: src/hds_pkg.sv
// shared types, constants and the coupling weight lookup for the diffusion stencil unit
// no dependencies; used by every other file of the block
package hds_pkg;

  localparam int VOLT_W = 16;
  localparam int KIND_W = 2;
  localparam int COEF_W = 16;
  localparam int SITE_BITS = VOLT_W + KIND_W;
  localparam int ROW_BITS = 2 * SITE_BITS;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int DIFF_W = VOLT_W + 1;
  localparam int TERM_W = DIFF_W + COEF_W;
  localparam int SUM_W = TERM_W + 2;
  localparam int PROD_W = SUM_W + COEF_W;
  localparam int DELTA_W = PROD_W + 1 - 32;
  localparam int RES_W = DELTA_W + 1;

  localparam logic [KIND_W-1:0] KIND_PASSIVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXCITABLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OSCILLATORY = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_COEF_LIKE_EXC = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_EXC_OTHER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_LIKE_OSC = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_OSC_OTHER = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_GAIN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 3'd6;

  localparam logic [COEF_W-1:0] RST_COEF_LIKE_EXC = 16'd32768;
  localparam logic [COEF_W-1:0] RST_COEF_EXC_OTHER = 16'd0;
  localparam logic [COEF_W-1:0] RST_COEF_LIKE_OSC = 16'd0;
  localparam logic [COEF_W-1:0] RST_COEF_OSC_OTHER = 16'd0;
  localparam logic [COEF_W-1:0] RST_STEP_GAIN = 16'd6554;
  localparam logic [10:0] RST_GRID_WIDTH = 11'd602;
  localparam logic [15:0] RST_GRID_HEIGHT = 16'd602;

  typedef struct packed {
    logic [COEF_W-1:0] coef_like_excitable;
    logic [COEF_W-1:0] coef_excitable_to_other;
    logic [COEF_W-1:0] coef_like_oscillatory;
    logic [COEF_W-1:0] coef_oscillatory_to_other;
    logic [COEF_W-1:0] step_gain;
    logic [10:0] grid_width;
    logic [15:0] grid_height;
  } cfg_t;

  // centre plus its four neighbours, ready for the arithmetic
  typedef struct packed {
    logic valid;
    logic last;
    logic [VOLT_W-1:0] v_c;
    logic [KIND_W-1:0] k_c;
    logic [3:0][VOLT_W-1:0] v_nb;
    logic [3:0][KIND_W-1:0] k_nb;
  } win_t;

  function automatic logic [COEF_W-1:0] weight_of(input logic [KIND_W-1:0] ck,
                                                  input logic [KIND_W-1:0] nk,
                                                  input cfg_t cfg);
    logic [COEF_W-1:0] w;
    w = '0;
    case (ck)
      KIND_EXCITABLE: begin
        w = (nk == KIND_EXCITABLE) ? cfg.coef_like_excitable : cfg.coef_excitable_to_other;
      end
      KIND_OSCILLATORY: begin
        w = (nk == KIND_OSCILLATORY) ? cfg.coef_like_oscillatory
                                     : cfg.coef_oscillatory_to_other;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: src/hds_ifs.sv
// valid/ready channel interfaces for lattice sites in and updated voltages out
// depends on hds_pkg
interface hds_site_if;
  logic valid;
  logic ready;
  logic signed [hds_pkg::VOLT_W-1:0] site_voltage;
  logic [hds_pkg::KIND_W-1:0] site_kind;
  modport source (output valid, site_voltage, site_kind, input ready);
  modport sink (input valid, site_voltage, site_kind, output ready);
endinterface

interface hds_result_if;
  logic valid;
  logic ready;
  logic signed [hds_pkg::VOLT_W-1:0] new_voltage;
  logic frame_last;
  modport source (output valid, new_voltage, frame_last, input ready);
  modport sink (input valid, new_voltage, frame_last, output ready);
endinterface

// File: src/hds_cfg.sv
// configuration register file, written through a plain index/data port
// depends on hds_pkg
module hds_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [hds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_data,
  output hds_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_like_excitable <= hds_pkg::RST_COEF_LIKE_EXC;
      cfg.coef_excitable_to_other <= hds_pkg::RST_COEF_EXC_OTHER;
      cfg.coef_like_oscillatory <= hds_pkg::RST_COEF_LIKE_OSC;
      cfg.coef_oscillatory_to_other <= hds_pkg::RST_COEF_OSC_OTHER;
      cfg.step_gain <= hds_pkg::RST_STEP_GAIN;
      cfg.grid_width <= hds_pkg::RST_GRID_WIDTH;
      cfg.grid_height <= hds_pkg::RST_GRID_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hds_pkg::REG_COEF_LIKE_EXC: cfg.coef_like_excitable <= cfg_data;
        hds_pkg::REG_COEF_EXC_OTHER: cfg.coef_excitable_to_other <= cfg_data;
        hds_pkg::REG_COEF_LIKE_OSC: cfg.coef_like_oscillatory <= cfg_data;
        hds_pkg::REG_COEF_OSC_OTHER: cfg.coef_oscillatory_to_other <= cfg_data;
        hds_pkg::REG_STEP_GAIN: cfg.step_gain <= cfg_data;
        hds_pkg::REG_GRID_WIDTH: cfg.grid_width <= cfg_data[10:0];
        hds_pkg::REG_GRID_HEIGHT: cfg.grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/hds_window.sv
// raster counters, two-row line memory and the stencil window registers
// depends on hds_pkg
module hds_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic in_valid,
  input  logic [hds_pkg::VOLT_W-1:0] in_voltage,
  input  logic [hds_pkg::KIND_W-1:0] in_kind,
  input  hds_pkg::cfg_t cfg,
  output hds_pkg::win_t win
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int GW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int VW = hds_pkg::VOLT_W;
  localparam int KW = hds_pkg::KIND_W;
  localparam int SB = hds_pkg::SITE_BITS;

  logic [CW-1:0] col;
  logic [15:0] row;
  logic [GW-1:0] w_eff;
  logic [15:0] h_eff;
  logic [GW-1:0] col_inc;
  logic [16:0] row_inc;
  logic [CW-1:0] col_next;
  logic [15:0] row_next;
  logic at_emit;
  logic at_last;

  logic s1_valid;
  logic s1_emit;
  logic s1_last;
  logic [CW-1:0] s1_col;
  logic [VW-1:0] s1_v;
  logic [KW-1:0] s1_k;

  logic [hds_pkg::ROW_BITS-1:0] line_mem [MAX_WIDTH];
  logic [hds_pkg::ROW_BITS-1:0] rd_word;
  logic [SB-1:0] rd_mid;
  logic [SB-1:0] rd_top;

  logic [VW-1:0] top1_v, top2_v, mid0_v, mid1_v, mid2_v, bot1_v, bot2_v;
  logic [KW-1:0] top1_k, top2_k, mid0_k, mid1_k, mid2_k, bot1_k, bot2_k;
  logic win_valid;
  logic win_last;

  always_comb begin
    if (cfg.grid_width < 11'd3) begin
      w_eff = GW'(3);
    end else if (GW'(cfg.grid_width) > GW'(MAX_WIDTH)) begin
      w_eff = GW'(MAX_WIDTH);
    end else begin
      w_eff = GW'(cfg.grid_width);
    end
    h_eff = (cfg.grid_height < 16'd3) ? 16'd3 : cfg.grid_height;
    col_inc = GW'(col) + GW'(1);
    row_inc = {1'b0, row} + 17'd1;
    at_emit = (row >= 16'd2) && (GW'(col) >= GW'(2));
    at_last = (row == h_eff - 16'd1) && (GW'(col) == w_eff - GW'(1));
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= {1'b0, h_eff}) ? 16'd0 : row_inc[15:0];
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = row;
    end
  end

  // counters and stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      if (in_valid) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_emit <= at_emit;
      s1_last <= at_last;
      s1_col <= col;
      s1_v <= in_voltage;
      s1_k <= in_kind;
    end
  end

  // line memory word: newer row in the upper half, older row in the lower half
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_word <= line_mem[col];
    end
    if (advance && s1_valid) begin
      line_mem[s1_col] <= {s1_v, s1_k, rd_mid};
    end
  end

  assign rd_mid = rd_word[hds_pkg::ROW_BITS-1 -: SB];
  assign rd_top = rd_word[SB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      top1_v <= '0; top2_v <= '0; mid0_v <= '0; mid1_v <= '0; mid2_v <= '0;
      bot1_v <= '0; bot2_v <= '0;
      top1_k <= '0; top2_k <= '0; mid0_k <= '0; mid1_k <= '0; mid2_k <= '0;
      bot1_k <= '0; bot2_k <= '0;
      win_valid <= 1'b0;
      win_last <= 1'b0;
    end else if (advance) begin
      win_valid <= s1_valid && s1_emit;
      win_last <= s1_last;
      if (s1_valid) begin
        top1_v <= top2_v;
        top2_v <= rd_top[SB-1 -: VW];
        mid0_v <= mid1_v;
        mid1_v <= mid2_v;
        mid2_v <= rd_mid[SB-1 -: VW];
        bot1_v <= bot2_v;
        bot2_v <= s1_v;
        top1_k <= top2_k;
        top2_k <= rd_top[KW-1:0];
        mid0_k <= mid1_k;
        mid1_k <= mid2_k;
        mid2_k <= rd_mid[KW-1:0];
        bot1_k <= bot2_k;
        bot2_k <= s1_k;
      end
    end
  end

  always_comb begin
    win.valid = win_valid;
    win.last = win_last;
    win.v_c = mid1_v;
    win.k_c = mid1_k;
    win.v_nb = {bot1_v, top1_v, mid2_v, mid0_v};
    win.k_nb = {bot1_k, top1_k, mid2_k, mid0_k};
  end

endmodule

// File: src/hds_math.sv
// weighted neighbour differences, coupling sum, gain, rounding and saturation
// depends on hds_pkg; ends in the output register
module hds_math (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  hds_pkg::win_t win,
  input  hds_pkg::cfg_t cfg,
  output logic out_valid,
  output logic signed [hds_pkg::VOLT_W-1:0] out_voltage,
  output logic out_last
);

  localparam int VW = hds_pkg::VOLT_W;
  localparam int DW = hds_pkg::DIFF_W;
  localparam int CWID = hds_pkg::COEF_W;
  localparam int TW = hds_pkg::TERM_W;
  localparam int SW = hds_pkg::SUM_W;
  localparam int PW = hds_pkg::PROD_W;
  localparam int XW = hds_pkg::DELTA_W;
  localparam int RW = hds_pkg::RES_W;

  logic a_valid, b_valid, c_valid, d_valid;
  logic a_last, b_last, c_last, d_last;
  logic signed [VW-1:0] a_vc, b_vc, c_vc, d_vc;
  logic signed [DW-1:0] a_d [4];
  logic [CWID-1:0] a_w [4];
  logic signed [TW-1:0] b_p [4];
  logic signed [SW-1:0] c_sum;
  logic signed [PW-1:0] d_prod;

  logic signed [DW-1:0] diff [4];
  logic [CWID-1:0] wsel [4];
  logic signed [TW:0] p_full [4];
  logic signed [SW-1:0] sum_comb;
  logic signed [PW+CWID:0] prod_full;
  logic signed [PW:0] biased;
  logic signed [XW-1:0] delta;
  logic signed [RW-1:0] res;
  logic signed [VW-1:0] sat;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff[i] = $signed({win.v_nb[i][VW-1], win.v_nb[i]}) - $signed({win.v_c[VW-1], win.v_c});
      wsel[i] = hds_pkg::weight_of(win.k_c, win.k_nb[i], cfg);
      p_full[i] = a_d[i] * $signed({1'b0, a_w[i]});
    end
    sum_comb = {{2{b_p[0][TW-1]}}, b_p[0]} + {{2{b_p[1][TW-1]}}, b_p[1]}
             + {{2{b_p[2][TW-1]}}, b_p[2]} + {{2{b_p[3][TW-1]}}, b_p[3]};
    prod_full = c_sum * $signed({1'b0, cfg.step_gain});
    // round half up to 1/128 mV
    biased = {d_prod[PW-1], d_prod} + $signed((PW+1)'(33'h0_8000_0000));
    delta = biased[PW -: XW];
    res = {{(RW-VW){d_vc[VW-1]}}, d_vc} + {delta[XW-1], delta};
    if (res > $signed(RW'(32767))) begin
      sat = 16'sh7fff;
    end else if (res < -$signed(RW'(32768))) begin
      sat = 16'sh8000;
    end else begin
      sat = res[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= win.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_last <= win.last;
      a_vc <= win.v_c;
      for (int i = 0; i < 4; i++) begin
        a_d[i] <= diff[i];
        a_w[i] <= wsel[i];
        b_p[i] <= p_full[i][TW-1:0];
      end
      b_last <= a_last;
      b_vc <= a_vc;
      c_last <= b_last;
      c_vc <= b_vc;
      c_sum <= sum_comb;
      d_last <= c_last;
      d_vc <= c_vc;
      d_prod <= prod_full[PW-1:0];
      out_last <= d_last;
      out_voltage <= sat;
    end
  end

endmodule

// File: src/heterogeneous_diffusion_stencil_unit.sv
// top level of the heterogeneous five-point diffusion stencil unit
// depends on hds_pkg, hds_ifs, hds_cfg, hds_window, hds_math
//
//   port         kind        word
//   site_in      sink        site_voltage, site_kind (one lattice site, raster order)
//   result_out   source      new_voltage, frame_last (one interior site)
//   cfg_*        write port  cfg_index selects register, cfg_data is the value
//
// one site per clock unless output stalls; path: s1, window, a, b, c, d, output registers
// the row memory is read and written at most once per advancing cycle, one entry per column
// reset clears counters, window and valid bits; the row memory is not cleared
// while an output word waits, the whole pipeline holds and site_in.ready is low
module heterogeneous_diffusion_stencil_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  hds_site_if.sink site_in,
  hds_result_if.source result_out,
  input  logic cfg_we,
  input  logic [hds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_data
);

  hds_pkg::cfg_t cfg;
  hds_pkg::win_t win;
  logic advance;
  logic out_valid;
  logic signed [hds_pkg::VOLT_W-1:0] out_voltage;
  logic out_last;

  assign advance = !out_valid || result_out.ready;
  assign site_in.ready = advance;
  assign result_out.valid = out_valid;
  assign result_out.new_voltage = out_voltage;
  assign result_out.frame_last = out_last;

  hds_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  hds_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(site_in.valid),
    .in_voltage(site_in.site_voltage),
    .in_kind(site_in.site_kind),
    .cfg(cfg),
    .win(win)
  );

  hds_math u_math (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .win(win),
    .cfg(cfg),
    .out_valid(out_valid),
    .out_voltage(out_voltage),
    .out_last(out_last)
  );

endmodule
